// File: rtl/core/swmm_pkg.sv
package swmm_pkg;

    // fixed field widths
    localparam int SAMPLE_W       = 32;
    localparam int LEN_W          = 7;

    // defaults
    localparam int DEF_MAX_WINDOW = 64;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    // request sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_RUN,
        ST_HOLD
    } t_state;

endpackage

// File: rtl/core/swmm_ifs.sv
// input request channel
interface swmm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [swmm_pkg::SAMPLE_W-1:0]   sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

// result request channel
interface swmm_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [swmm_pkg::SAMPLE_W-1:0]   window_mean;
    logic signed [swmm_pkg::SAMPLE_W-1:0]   window_maximum;
    logic        [swmm_pkg::LEN_W-1:0]      held_count;

    modport source (output valid, output window_mean, output window_maximum,
                    output held_count, input ready);
    modport sink   (input valid, input window_mean, input window_maximum,
                    input held_count, output ready);
endinterface

// File: rtl/core/sliding_window_mean_max_unit.sv
// Channel    | Dir | Payload                                   | Accepted when
// -----------+-----+-------------------------------------------+--------------
// i_sample   | in  | sample_value                              | valid & ready
// o_result   | out | window_mean, window_maximum, held_count   | valid & ready
// i_cfg_*    | in  | window_length                             | i_cfg_we
//
// One request at a time, accept to next accept, paced by the serial divider and
// the one-entry-a-cycle maximum scan over the held samples, which run side by side.
// Reset (synchronous, i_rst_n low) empties the window; no clearing pass.
// A finished result waits in the output register while the next request is
// taken; a stalled output holds the block before it loads a new result.
module sliding_window_mean_max_unit #(
    parameter int MAX_WINDOW = swmm_pkg::DEF_MAX_WINDOW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [swmm_pkg::LEN_W-1:0]  i_cfg_wdata,
    swmm_in_if.sink                     i_sample,
    swmm_out_if.source                  o_result
);

    localparam int SW    = swmm_pkg::SAMPLE_W;
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CNT_W = (AW + 1 > swmm_pkg::LEN_W) ? AW + 1 : swmm_pkg::LEN_W;
    localparam int TW    = SW + AW + 1;

    swmm_pkg::t_state r_state, n_state;

    logic [swmm_pkg::LEN_W-1:0] r_wl;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [AW-1:0]              r_oldest, n_oldest;
    logic signed [TW-1:0]       r_total, n_total;
    logic [SW-1:0]              r_sample;
    logic [AW-1:0]              r_slot;
    logic                       r_full;
    logic                       r_scan_got;
    logic                       r_div_got;

    logic                       r_out_valid;
    logic signed [SW-1:0]       r_mean;
    logic signed [SW-1:0]       r_max;
    logic [swmm_pkg::LEN_W-1:0] r_count;

    logic [CNT_W-1:0]           wl_ext;
    logic [CNT_W-1:0]           eff_len;
    logic                       accept;
    logic                       full;
    logic [AW-1:0]              slot;
    logic [CNT_W-1:0]           slot_inc;
    logic [SW-1:0]              old_sample;
    logic signed [TW-1:0]       old_ext;
    logic signed [TW-1:0]       new_ext;
    logic                       load_out;
    logic                       out_free;

    logic                       in_ready;
    logic                       do_update;
    logic                       want_load;

    logic                       scan_done;
    logic                       div_done;
    logic signed [SW-1:0]       div_quotient;
    logic signed [SW-1:0]       scan_max;

    // effective window length: zero means one, capped at the store depth
    assign wl_ext  = CNT_W'(r_wl);
    assign eff_len = (r_wl == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} :
                     (wl_ext > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : wl_ext;

    assign accept   = i_sample.valid && in_ready;
    assign full     = r_fill >= eff_len;
    assign slot     = full ? r_oldest : r_fill[AW-1:0];
    assign out_free = !r_out_valid || o_result.ready;
    assign load_out = want_load && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swmm_pkg::ST_IDLE:   if (accept) n_state = swmm_pkg::ST_UPDATE;
            swmm_pkg::ST_UPDATE: n_state = swmm_pkg::ST_RUN;
            swmm_pkg::ST_RUN:    if (r_scan_got && r_div_got) n_state = swmm_pkg::ST_HOLD;
            swmm_pkg::ST_HOLD:   if (out_free) n_state = swmm_pkg::ST_IDLE;
            default:             n_state = swmm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready  = 1'b0;
        do_update = 1'b0;
        want_load = 1'b0;
        unique case (r_state)
            swmm_pkg::ST_IDLE:   in_ready  = 1'b1;
            swmm_pkg::ST_UPDATE: do_update = 1'b1;
            swmm_pkg::ST_RUN:    ;
            swmm_pkg::ST_HOLD:   want_load = 1'b1;
            default:             ;
        endcase
    end

    // read-modify-write of the running sum; old sample arrives in UPDATE
    assign old_ext  = {{(TW-SW){old_sample[SW-1]}}, old_sample};
    assign new_ext  = {{(TW-SW){r_sample[SW-1]}}, r_sample};
    assign slot_inc = CNT_W'(r_slot) + {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_total  = r_total + new_ext - (r_full ? old_ext : '0);
        n_fill   = r_fill;
        n_oldest = r_oldest;
        if (r_full) begin
            n_oldest = (slot_inc == eff_len) ? '0 : slot_inc[AW-1:0];
        end else begin
            n_fill = r_fill + {{(CNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= swmm_pkg::ST_IDLE;
            r_wl     <= swmm_pkg::LEN_RESET;
            r_fill   <= '0;
            r_oldest <= '0;
            r_total  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_wl     <= i_cfg_wdata;
                r_fill   <= '0;
                r_oldest <= '0;
                r_total  <= '0;
            end else if (do_update) begin
                r_fill   <= n_fill;
                r_oldest <= n_oldest;
                r_total  <= n_total;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample.sample_value;
            r_slot   <= slot;
            r_full   <= full;
        end
    end

    // unit completion flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_got <= 1'b0;
            r_div_got  <= 1'b0;
        end else if (do_update) begin
            r_scan_got <= 1'b0;
            r_div_got  <= 1'b0;
        end else begin
            if (scan_done) r_scan_got <= 1'b1;
            if (div_done)  r_div_got  <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_mean  <= div_quotient;
            r_max   <= scan_max;
            r_count <= r_fill[swmm_pkg::LEN_W-1:0];
        end
    end

    swmm_store #(
        .MAX_WINDOW (MAX_WINDOW),
        .CNT_W      (CNT_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (do_update),
        .i_wr_addr    (r_slot),
        .i_wr_data    (r_sample),
        .i_rd_en      (accept),
        .i_rd_addr    (slot),
        .o_rd_data    (old_sample),
        .i_scan_start (do_update),
        .i_scan_count (n_fill),
        .o_scan_done  (scan_done),
        .o_max        (scan_max)
    );

    swmm_div #(
        .DIVIDEND_W (TW),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (do_update),
        .i_dividend (n_total),
        .i_divisor  (n_fill),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign i_sample.ready          = in_ready;
    assign o_result.valid          = r_out_valid;
    assign o_result.window_mean    = r_mean;
    assign o_result.window_maximum = r_max;
    assign o_result.held_count     = r_count;

`ifndef SYNTHESIS
    // window never holds more than its length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_len)
        else $error("fill count beyond window length");

    // oldest pointer stays inside the window
    a_oldest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_oldest) < eff_len)
        else $error("oldest slot outside window");

    // a result is only raised once both units have finished
    a_load_after_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_scan_got && r_div_got))
        else $error("result loaded before scan and divide finished");

    // a delivered result always covers at least one sample
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_count != '0))
        else $error("result with empty window");
`endif

endmodule

// File: rtl/core/swmm_store.sv
// Sample memory with one read port shared by the old-sample fetch and the
// maximum scan, plus the scan sequencer and running maximum.
module swmm_store #(
    parameter int MAX_WINDOW = swmm_pkg::DEF_MAX_WINDOW,
    parameter int CNT_W      = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [$clog2(MAX_WINDOW)-1:0]        i_wr_addr,
    input  logic [swmm_pkg::SAMPLE_W-1:0]        i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [$clog2(MAX_WINDOW)-1:0]        i_rd_addr,
    output logic [swmm_pkg::SAMPLE_W-1:0]        o_rd_data,
    input  logic                                 i_scan_start,
    input  logic [CNT_W-1:0]                     i_scan_count,
    output logic                                 o_scan_done,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] o_max
);

    localparam int AW = $clog2(MAX_WINDOW);

    logic [swmm_pkg::SAMPLE_W-1:0] r_mem [MAX_WINDOW];
    logic [swmm_pkg::SAMPLE_W-1:0] r_rd_data;
    logic [CNT_W-1:0]              r_idx;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_busy;
    logic                          r_vld;
    logic                          r_last;
    logic                          r_first;
    logic                          r_done;
    logic signed [swmm_pkg::SAMPLE_W-1:0] r_max;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            last_issue;
    logic signed [swmm_pkg::SAMPLE_W-1:0] rd_signed;

    // scan owns the read port while busy
    assign rd_en      = r_busy | i_rd_en;
    assign rd_addr    = r_busy ? r_idx[AW-1:0] : i_rd_addr;
    assign last_issue = r_busy && (r_idx == (r_cnt - {{(CNT_W-1){1'b0}}, 1'b1}));
    assign rd_signed  = $signed(r_rd_data);

    // memory write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // memory read, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // scan sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= 1'b0;
            r_last <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
            r_cnt  <= '0;
        end else begin
            r_vld  <= r_busy;
            r_last <= last_issue;
            r_done <= r_vld && r_last;
            if (i_scan_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_cnt  <= i_scan_count;
            end else if (r_busy) begin
                r_idx <= r_idx + {{(CNT_W-1){1'b0}}, 1'b1};
                if (last_issue) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // running maximum
    always_ff @(posedge i_clk) begin
        if (i_scan_start) begin
            r_first <= 1'b1;
        end else if (r_vld) begin
            r_first <= 1'b0;
            if (r_first || (rd_signed > r_max)) begin
                r_max <= rd_signed;
            end
        end
    end

    assign o_rd_data   = r_rd_data;
    assign o_scan_done = r_done;
    assign o_max       = r_max;

endmodule

// File: rtl/core/swmm_div.sv
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
module swmm_div #(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [DIVIDEND_W-1:0]         i_dividend,
    input  logic [DIVISOR_W-1:0]                 i_divisor,
    output logic                                 o_done,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dsr;
    logic [STEP_W-1:0]     r_step;
    logic                  r_busy;
    logic                  r_neg;
    logic                  r_done;
    logic [swmm_pkg::SAMPLE_W-1:0] r_result;

    logic [DIVIDEND_W-1:0] mag;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  fits;
    logic [DIVISOR_W:0]    rem_sub;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVIDEND_W-1:0] quo_signed;

    assign mag      = i_dividend[DIVIDEND_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign rem_sh   = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits     = rem_sh >= {1'b0, r_dsr};
    assign rem_sub  = rem_sh - {1'b0, r_dsr};
    assign quo_next = {r_quo[DIVIDEND_W-2:0], fits};
    assign quo_signed = r_neg ? (~quo_next + 1'b1) : quo_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + {{(STEP_W-1){1'b0}}, 1'b1};
                if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_neg <= i_dividend[DIVIDEND_W-1];
        end else if (r_busy) begin
            r_quo <= quo_next;
            r_rem <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                r_result <= quo_signed[swmm_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = $signed(r_result);

endmodule

// File: tb/sliding_window_mean_max_unit_tb.sv
module sliding_window_mean_max_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W      = swmm_pkg::SAMPLE_W;
    localparam int LEN_W         = swmm_pkg::LEN_W;
    localparam int MAX_WIN       = swmm_pkg::DEF_MAX_WINDOW;
    localparam int RANDOM_PUSHES = 1250;
    localparam int TAIL_CYCLES   = 80;

    // one result as the block reports it
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] maximum;
        logic        [LEN_W-1:0]    count;
    } t_window_result;

    // directed stimulus rows
    typedef enum logic [1:0] {
        ROW_SET_LEN,
        ROW_PUSH,
        ROW_PUSH_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic        [SAMPLE_W-1:0] value;
        logic signed [SAMPLE_W-1:0] exp_mean;
        logic signed [SAMPLE_W-1:0] exp_max;
        logic        [LEN_W-1:0]    exp_count;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 26;
    localparam t_stim_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        // reset length of 64: largest positive, then most negative
        '{ROW_PUSH_KNOWN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd1},
        '{ROW_PUSH_KNOWN, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 7'd2},
        '{ROW_PUSH,       32'h8000_0000, 32'h0, 32'h0, 7'd0},
        '{ROW_PUSH,       32'h0001_8000, 32'h0, 32'h0, 7'd0},
        '{ROW_PUSH,       32'hFFFF_0000, 32'h0, 32'h0, 7'd0},
        // single-sample window
        '{ROW_SET_LEN,    32'd1,         32'h0, 32'h0, 7'd0},
        '{ROW_PUSH_KNOWN, 32'hFFFF_FFFB, 32'hFFFF_FFFB, 32'hFFFF_FFFB, 7'd1},
        '{ROW_PUSH_KNOWN, 32'h0000_0007, 32'h0000_0007, 32'h0000_0007, 7'd1},
        // length zero behaves as one
        '{ROW_SET_LEN,    32'd0,         32'h0, 32'h0, 7'd0},
        '{ROW_PUSH_KNOWN, 32'h0000_0003, 32'h0000_0003, 32'h0000_0003, 7'd1},
        '{ROW_PUSH_KNOWN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 7'd1},
        // two deep: negative mean truncates toward zero
        '{ROW_SET_LEN,    32'd2,         32'h0, 32'h0, 7'd0},
        '{ROW_PUSH_KNOWN, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 7'd1},
        '{ROW_PUSH_KNOWN, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h0000_0001, 7'd2},
        '{ROW_PUSH_KNOWN, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 7'd2},
        '{ROW_PUSH,       32'h7FFF_FFFF, 32'h0, 32'h0, 7'd0},
        // length above the store depth saturates
        '{ROW_SET_LEN,    32'd127,       32'h0, 32'h0, 7'd0},
        '{ROW_PUSH_KNOWN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 7'd1},
        '{ROW_PUSH,       32'h0000_0000, 32'h0, 32'h0, 7'd0},
        '{ROW_PUSH,       32'hFFFF_FFFF, 32'h0, 32'h0, 7'd0},
        // three deep, wrapped past the oldest slot
        '{ROW_SET_LEN,    32'd3,         32'h0, 32'h0, 7'd0},
        '{ROW_PUSH,       32'hFFFF_FFFF, 32'h0, 32'h0, 7'd0},
        '{ROW_PUSH,       32'hFFFF_FFFE, 32'h0, 32'h0, 7'd0},
        '{ROW_PUSH,       32'hFFFF_FFFD, 32'h0, 32'h0, 7'd0},
        '{ROW_PUSH,       32'h000A_0000, 32'h0, 32'h0, 7'd0},
        '{ROW_PUSH,       32'h8000_0001, 32'h0, 32'h0, 7'd0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LEN_W-1:0]   i_cfg_wdata;

    swmm_in_if  sample_if ();
    swmm_out_if result_if ();

    sliding_window_mean_max_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (sample_if),
        .o_result    (result_if)
    );

    // shadow of the window
    logic signed [SAMPLE_W-1:0] win_samples [MAX_WIN];
    int unsigned                win_oldest;
    int unsigned                win_fill;
    longint                     win_sum;
    logic        [LEN_W-1:0]    win_len_reg;

    t_window_result window_results_due [$];

    int samples_pushed;
    int results_seen;
    int mismatch_count;
    int length_writes;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // push one sample into the shadow window and work out the result
    function automatic t_window_result predict_window_push(input logic signed [SAMPLE_W-1:0] s);
        t_window_result res;
        int unsigned    len;
        int unsigned    slot;
        longint         best;
        longint         v;
        len = (win_len_reg == '0) ? 1 :
              (win_len_reg > MAX_WIN) ? MAX_WIN : int'(win_len_reg);
        if (win_fill >= len) begin
            // full: the oldest sample makes way
            slot       = win_oldest % len;
            win_sum    = win_sum - longint'(win_samples[slot]);
            win_samples[slot] = s;
            win_sum    = win_sum + longint'(s);
            win_oldest = (slot + 1) % len;
            win_fill   = len;
        end else begin
            slot = (win_oldest + win_fill) % len;
            win_samples[slot] = s;
            win_sum  = win_sum + longint'(s);
            win_fill = win_fill + 1;
        end
        best = longint'(win_samples[win_oldest % len]);
        for (int unsigned i = 0; i < win_fill; i++) begin
            v = longint'(win_samples[(win_oldest + i) % len]);
            if (v > best) best = v;
        end
        res.mean    = SAMPLE_W'(win_sum / longint'(win_fill));
        res.maximum = SAMPLE_W'(best);
        res.count   = LEN_W'(win_fill);
        return res;
    endfunction

    // sender gap: mostly none or short, now and then long
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 11);
        case (r)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            3, 4, 5: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    // offer one request after a gap, hold until taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input int gap,
                               input bit known, input t_window_result known_res);
        t_window_result res;
        if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.sample_value <= value;
        do @(posedge i_clk); while (!sample_if.ready);
        res = predict_window_push(value);
        window_results_due.insert(window_results_due.size(), known ? known_res : res);
        samples_pushed++;
    endtask

    // hold off new requests until every result is back
    task automatic drain_results();
        sample_if.valid <= 1'b0;
        do @(posedge i_clk); while (window_results_due.size() != 0);
    endtask

    // register write, only with the block idle
    task automatic write_window_length(input logic [LEN_W-1:0] len);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        win_len_reg = len;
        win_oldest  = 0;
        win_fill    = 0;
        win_sum     = 0;
        length_writes++;
    endtask

    // result side back-pressure
    int rx_stall_left  = 0;
    int rx_steady_left = 0;
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            result_if.ready <= 1'b0;
            rx_stall_left--;
        end else begin
            result_if.ready <= 1'b1;
            if (rx_steady_left > 0) begin
                rx_steady_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10)      rx_stall_left  = $urandom_range(1, 3);
                else if (r < 13) rx_stall_left  = $urandom_range(10, 40);
                else if (r < 14) rx_steady_left = $urandom_range(100, 300);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_window_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            results_seen++;
            if (window_results_due.size() == 0) begin
                $display("%0t: result with none outstanding: mean %h max %h count %0d",
                         $time, result_if.window_mean, result_if.window_maximum,
                         result_if.held_count);
                mismatch_count++;
            end else begin
                want = window_results_due.pop_front();
                if (result_if.window_mean !== want.mean) begin
                    $display("%0t: window_mean expected %h got %h",
                             $time, want.mean, result_if.window_mean);
                    mismatch_count++;
                end
                if (result_if.window_maximum !== want.maximum) begin
                    $display("%0t: window_maximum expected %h got %h",
                             $time, want.maximum, result_if.window_maximum);
                    mismatch_count++;
                end
                if (result_if.held_count !== want.count) begin
                    $display("%0t: held_count expected %0d got %0d",
                             $time, want.count, result_if.held_count);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_window_result known_res;
        logic [LEN_W-1:0] len;
        int  eff_len;
        int  burst;
        int  random_done;
        int  r;
        bit  steady;

        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_wdata            <= '0;
        sample_if.valid        <= 1'b0;
        sample_if.sample_value <= '0;
        samples_pushed         = 0;
        results_seen           = 0;
        mismatch_count         = 0;
        length_writes          = 0;
        random_done            = 0;
        win_len_reg            = swmm_pkg::LEN_RESET;
        win_oldest             = 0;
        win_fill               = 0;
        win_sum                = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            known_res.mean    = DIRECTED[i].exp_mean;
            known_res.maximum = DIRECTED[i].exp_max;
            known_res.count   = DIRECTED[i].exp_count;
            case (DIRECTED[i].kind)
                ROW_SET_LEN: write_window_length(LEN_W'(DIRECTED[i].value));
                ROW_PUSH_KNOWN: send_sample(DIRECTED[i].value, pick_gap(1'b0), 1'b1, known_res);
                default: send_sample(DIRECTED[i].value, pick_gap(1'b0), 1'b0, known_res);
            endcase
        end

        // random phases, each under a fresh window length
        while (random_done < RANDOM_PUSHES) begin
            r = $urandom_range(0, 19);
            if (r < 2)       len = 7'd1;
            else if (r < 5)  len = 7'd64;
            else if (r < 6)  len = 7'd0;
            else if (r < 7)  len = LEN_W'($urandom_range(65, 127));
            else if (r < 15) len = LEN_W'($urandom_range(2, 12));
            else             len = LEN_W'($urandom_range(13, 63));
            write_window_length(len);
            eff_len = (len == '0) ? 1 : (len > MAX_WIN) ? MAX_WIN : int'(len);
            burst   = $urandom_range(1, 3 * eff_len + 4);
            steady  = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < burst && random_done < RANDOM_PUSHES; k++) begin
                if ($urandom_range(0, 49) == 0) drain_results();
                send_sample(pick_sample(), pick_gap(steady), 1'b0, known_res);
                random_done++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Pushed %0d samples over %0d window length settings; %0d results checked,",
                 samples_pushed, length_writes, results_seen);
        $display("%0d outstanding at the end, %0d mismatches.",
                 window_results_due.size(), mismatch_count);
        if (mismatch_count == 0 && window_results_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/swmm_pkg.sv
rtl/core/swmm_ifs.sv
rtl/core/swmm_store.sv
rtl/core/swmm_div.sv
rtl/core/sliding_window_mean_max_unit.sv
tb/sliding_window_mean_max_unit_tb.sv
